>>> hdl/gf16ms_pkg.sv
// Shared types, constants and helpers for the GF(2^16) multi-source multiply-add.
// Used by gf16ms_mul, gf16_multi_source_muladd and the testbench; no dependencies.
package gf16ms_pkg;

    localparam int NUM_SRC   = 6;
    localparam int WORD_W    = 16;
    localparam int PROD_W    = 2 * WORD_W - 1;
    localparam int HI_W      = PROD_W - WORD_W;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 3;

    // Low part of x^16 + x^12 + x^3 + x + 1
    localparam logic [WORD_W-1:0] GF_POLY_LOW = 16'h100B;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_D       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_E       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_F       = 3'd6;

    // func codes
    localparam logic FUNC_MUL    = 1'b0;
    localparam logic FUNC_MULADD = 1'b1;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t             red_tbl_t [HI_W];

    // x^(16+k) mod P for k = 0..14, folded at elaboration
    function automatic red_tbl_t red_tbl_gen();
        red_tbl_t tbl;
        word_t    x;
        x = GF_POLY_LOW;
        for (int k = 0; k < HI_W; k++)
        begin
            tbl[k] = x;
            if (x[WORD_W-1])
                x = {x[WORD_W-2:0], 1'b0} ^ GF_POLY_LOW;
            else
                x = {x[WORD_W-2:0], 1'b0};
        end
        return tbl;
    endfunction

    localparam red_tbl_t RED_TBL = red_tbl_gen();

endpackage

>>> hdl/gf16_multi_source_muladd.sv
// Top level of the GF(2^16) multi-source multiply / multiply-add block.
// Depends on gf16ms_pkg and gf16ms_mul; checked by gf16ms_chk (bound).
//
// Each request carries one 16-bit word position from six source streams
// (src_a..src_f) plus the destination word. Every source word is multiplied
// by its coefficient (coef_a..coef_f) in GF(2^16) modulo x^16+x^12+x^3+x+1.
// func=1 (multiply-add): result = dst_word ^ sum of the first source_count
// products; a count of 0 acts as 1 and counts above MAX_SOURCES saturate.
// func=0 (multiply): result = coef_a * src_a; dst_word and count are unused.
// last_in rides along and comes out as last_out. Throughput is one request
// per cycle while out_stall is low; each request passes through the input
// register, then the six multipliers and XOR tree into the result register.
// Both stages hold under out_stall, and in_stall rises only when both are
// full and the output is stalled. Configuration writes are always ready
// (cfg_ready tied high); index 0 is source_count, 1..6 are coef_a..f, index
// 7 is ignored. Write configuration only while the block is empty.
module gf16_multi_source_muladd
#(
    parameter int MAX_SOURCES = 6
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [15:0] dst_word,
    input  logic [15:0] src_a,
    input  logic [15:0] src_b,
    input  logic [15:0] src_c,
    input  logic [15:0] src_d,
    input  logic [15:0] src_e,
    input  logic [15:0] src_f,
    input  logic        last_in,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] result_word,
    output logic        last_out
);

    localparam logic [gf16ms_pkg::CNT_W-1:0] MAX_CNT = gf16ms_pkg::CNT_W'(MAX_SOURCES);
    localparam logic [gf16ms_pkg::CNT_W-1:0] MIN_CNT = gf16ms_pkg::CNT_W'(1);

    // ---------------- configuration registers ----------------
    logic [gf16ms_pkg::CNT_W-1:0] source_count_reg;
    logic [gf16ms_pkg::CNT_W-1:0] source_count_next;
    gf16ms_pkg::word_t            coef_reg  [gf16ms_pkg::NUM_SRC];
    gf16ms_pkg::word_t            coef_next [gf16ms_pkg::NUM_SRC];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        source_count_next = source_count_reg;
        for (int j = 0; j < gf16ms_pkg::NUM_SRC; j++)
            coef_next[j] = coef_reg[j];
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gf16ms_pkg::REG_SOURCE_COUNT:
                    source_count_next = cfg_data[gf16ms_pkg::CNT_W-1:0];
                gf16ms_pkg::REG_COEF_A: coef_next[0] = cfg_data;
                gf16ms_pkg::REG_COEF_B: coef_next[1] = cfg_data;
                gf16ms_pkg::REG_COEF_C: coef_next[2] = cfg_data;
                gf16ms_pkg::REG_COEF_D: coef_next[3] = cfg_data;
                gf16ms_pkg::REG_COEF_E: coef_next[4] = cfg_data;
                gf16ms_pkg::REG_COEF_F: coef_next[5] = cfg_data;
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_count_reg <= MIN_CNT;
            for (int j = 0; j < gf16ms_pkg::NUM_SRC; j++)
                coef_reg[j] <= '0;
        end
        else
        begin
            source_count_reg <= source_count_next;
            for (int j = 0; j < gf16ms_pkg::NUM_SRC; j++)
                coef_reg[j] <= coef_next[j];
        end
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s2_adv, s1_adv;

    // stage advances when empty or its downstream is moving
    assign s2_adv   = !out_valid_reg || !out_stall;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_stall = !s1_adv;

    assign s1_valid_next  = s1_adv ? in_valid : s1_valid_reg;
    assign out_valid_next = s2_adv ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- input register ----------------
    logic              s1_func_reg;
    logic              s1_last_reg;
    gf16ms_pkg::word_t s1_dst_reg;
    gf16ms_pkg::word_t s1_src_reg [gf16ms_pkg::NUM_SRC];

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            s1_func_reg   <= func;
            s1_last_reg   <= last_in;
            s1_dst_reg    <= dst_word;
            s1_src_reg[0] <= src_a;
            s1_src_reg[1] <= src_b;
            s1_src_reg[2] <= src_c;
            s1_src_reg[3] <= src_d;
            s1_src_reg[4] <= src_e;
            s1_src_reg[5] <= src_f;
        end
    end

    // ---------------- multiply and accumulate ----------------
    logic [gf16ms_pkg::CNT_W-1:0] count_eff;
    logic [gf16ms_pkg::NUM_SRC-1:0] lane_en;
    gf16ms_pkg::word_t            lane_src  [gf16ms_pkg::NUM_SRC];
    gf16ms_pkg::word_t            lane_prod [gf16ms_pkg::NUM_SRC];
    gf16ms_pkg::word_t            result_next;

    // zero count behaves as one; above the build limit saturates
    always_comb
    begin
        if (source_count_reg == '0)
            count_eff = MIN_CNT;
        else if (source_count_reg > MAX_CNT)
            count_eff = MAX_CNT;
        else
            count_eff = source_count_reg;
    end

    for (genvar j = 0; j < gf16ms_pkg::NUM_SRC; j++)
    begin : g_lane
        // unused lanes are fed zero so their product drops out
        assign lane_en[j]  = (s1_func_reg == gf16ms_pkg::FUNC_MULADD)
                           ? (gf16ms_pkg::CNT_W'(j) < count_eff) : (j == 0);
        assign lane_src[j] = lane_en[j] ? s1_src_reg[j] : '0;

        gf16ms_mul u_mul
        (
            .a (coef_reg[j]),
            .b (lane_src[j]),
            .p (lane_prod[j])
        );
    end

    always_comb
    begin
        result_next = (s1_func_reg == gf16ms_pkg::FUNC_MULADD) ? s1_dst_reg : '0;
        for (int j = 0; j < gf16ms_pkg::NUM_SRC; j++)
            result_next = result_next ^ lane_prod[j];
    end

    // ---------------- result register ----------------
    gf16ms_pkg::word_t result_reg;
    logic              last_reg;

    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_valid_reg)
        begin
            result_reg <= result_next;
            last_reg   <= s1_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_word = result_reg;
    assign last_out    = last_reg;

endmodule

>>> hdl/gf16ms_mul.sv
// One GF(2^16) multiplier: carry-less product and constant-matrix reduction.
// Depends on gf16ms_pkg.
module gf16ms_mul
(
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic [15:0] p
);

    logic [gf16ms_pkg::PROD_W-1:0] clmul;
    logic [gf16ms_pkg::WORD_W-1:0] folded;

    // partial products are independent; XOR tree
    always_comb
    begin
        clmul = '0;
        for (int i = 0; i < gf16ms_pkg::WORD_W; i++)
        begin
            if (b[i])
                clmul = clmul ^ (gf16ms_pkg::PROD_W'(a) << i);
        end
    end

    // each high bit maps to a fixed residue
    always_comb
    begin
        folded = clmul[gf16ms_pkg::WORD_W-1:0];
        for (int k = 0; k < gf16ms_pkg::HI_W; k++)
        begin
            if (clmul[gf16ms_pkg::WORD_W + k])
                folded = folded ^ gf16ms_pkg::RED_TBL[k];
        end
    end

    assign p = folded;

endmodule

>>> hdl/gf16ms_chk.sv
// Port-level checker for gf16_multi_source_muladd, with its bind statement.
// Depends on gf16_multi_source_muladd port names only.
module gf16ms_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_ready,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] result_word,
    input logic        last_out
);

    // a held result keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_word) && $stable(last_out))
        else $error("stalled result changed");

    // input backs up only when the output is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // free cycles with no new request and no output stall drain the pipeline
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid && !out_stall) ##1 (!in_valid && !out_stall) |=> !out_valid)
        else $error("result appeared without a request");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");

endmodule

bind gf16_multi_source_muladd gf16ms_chk u_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ready   (cfg_ready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_word (result_word),
    .last_out    (last_out)
);

>>> tb/gf16_multi_source_muladd_tb.sv
// Self-checking testbench for gf16_multi_source_muladd: GF(2^16) multiply and
// multiply-add over six source streams, checked word by word against a predictor.
// Depends on gf16ms_pkg and the gf16_multi_source_muladd RTL; reads no files.
module gf16_multi_source_muladd_tb;

    localparam int MAX_SRC     = 6;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 155;
    // Timeout: far above the slowest correct run with gaps and stalls
    localparam int LIMIT_TIME  = 4_000_000;

    // Index 7 is outside the register list; writes there must do nothing
    localparam logic [gf16ms_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic                                             func;
        gf16ms_pkg::word_t                                dst;
        gf16ms_pkg::word_t [gf16ms_pkg::NUM_SRC-1:0]      src;   // src[0] = A ... src[5] = F
        logic                                             last;
    } word_req_t;

    typedef struct packed {
        gf16ms_pkg::word_t word;
        logic              last;
    } word_res_t;

    // Keeps a shadow of the registers, predicts each result and holds the
    // predictions in request order until the matching result shows up.
    class muladd_scoreboard;
        logic [gf16ms_pkg::CNT_W-1:0] src_count;
        gf16ms_pkg::word_t            coef [gf16ms_pkg::NUM_SRC];
        word_res_t                    expected_words [$];
        int                           errors;

        function new();
            src_count = 1;
            foreach (coef[i])
                coef[i] = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [gf16ms_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            if (idx == gf16ms_pkg::REG_SOURCE_COUNT)
                src_count = data[gf16ms_pkg::CNT_W-1:0];
            else if (idx >= gf16ms_pkg::REG_COEF_A && idx <= gf16ms_pkg::REG_COEF_F)
                coef[int'(idx) - int'(gf16ms_pkg::REG_COEF_A)] = data;
        endfunction

        // Carry-less multiply into 31 bits, then fold the top bits back down
        function gf16ms_pkg::word_t gf_product(gf16ms_pkg::word_t a, gf16ms_pkg::word_t b);
            logic [gf16ms_pkg::PROD_W-1:0] p;
            logic [gf16ms_pkg::WORD_W:0]   poly;
            p    = '0;
            poly = {1'b1, gf16ms_pkg::GF_POLY_LOW};
            for (int i = 0; i < gf16ms_pkg::WORD_W; i++)
                if (b[i])
                    p ^= gf16ms_pkg::PROD_W'(a) << i;
            for (int k = gf16ms_pkg::PROD_W - 1; k >= gf16ms_pkg::WORD_W; k--)
                if (p[k])
                    p ^= gf16ms_pkg::PROD_W'(poly) << (k - gf16ms_pkg::WORD_W);
            return p[gf16ms_pkg::WORD_W-1:0];
        endfunction

        function word_res_t predict(word_req_t r);
            word_res_t res;
            int        n;
            res.last = r.last;
            if (r.func == gf16ms_pkg::FUNC_MUL)
            begin
                res.word = gf_product(coef[0], r.src[0]);
            end
            else
            begin
                // zero count acts as one, anything above six saturates
                n = (src_count == 0) ? 1 : int'(src_count);
                if (n > MAX_SRC)
                    n = MAX_SRC;
                res.word = r.dst;
                for (int i = 0; i < n; i++)
                    res.word ^= gf_product(coef[i], r.src[i]);
            end
            return res;
        endfunction

        function void note_request(word_req_t r);
            expected_words.push_back(predict(r));
        endfunction

        function void check_result(gf16ms_pkg::word_t word, logic last);
            word_res_t exp_res;
            if (expected_words.size() == 0)
            begin
                $error("result_word: expected none, got %h (last_out %b)", word, last);
                errors++;
                return;
            end
            exp_res = expected_words.pop_front();
            if (word !== exp_res.word)
            begin
                $error("result_word: expected %h, got %h", exp_res.word, word);
                errors++;
            end
            if (last !== exp_res.last)
            begin
                $error("last_out: expected %b, got %b", exp_res.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    // Clock, reset and DUT ports; every input starts at a known value
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index   = '0;
    logic [15:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic        func        = gf16ms_pkg::FUNC_MUL;
    logic [15:0] dst_word    = '0;
    logic [15:0] src_a       = '0;
    logic [15:0] src_b       = '0;
    logic [15:0] src_c       = '0;
    logic [15:0] src_d       = '0;
    logic [15:0] src_e       = '0;
    logic [15:0] src_f       = '0;
    logic        last_in     = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [15:0] result_word;
    logic        last_out;

    int               stall_pct = 0;   // receiver back-pressure, percent of cycles
    muladd_scoreboard board     = new();

    gf16_multi_source_muladd #(
        .MAX_SOURCES (MAX_SRC)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .dst_word    (dst_word),
        .src_a       (src_a),
        .src_b       (src_b),
        .src_c       (src_c),
        .src_d       (src_d),
        .src_e       (src_e),
        .src_f       (src_f),
        .last_in     (last_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_word (result_word),
        .last_out    (last_out)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Random receiver stalls; stall_pct of zero gives a clean stretch
    always @(posedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);

    // Output monitor: values sampled at the edge are the pre-edge ones
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(result_word, last_out);

    // Hard stop in case a handshake never completes
    initial
    begin
        #(LIMIT_TIME);
        $display("** gf16_multi_source_muladd: FAILED **");
        $finish;
    end

    // Biased word: the corner values turn up far more often than by chance
    function automatic gf16ms_pkg::word_t pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001;
            3:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic word_req_t make_req(logic f, gf16ms_pkg::word_t dst,
                                           gf16ms_pkg::word_t s, logic last);
        word_req_t r;
        r.func = f;
        r.dst  = dst;
        r.last = last;
        for (int i = 0; i < gf16ms_pkg::NUM_SRC; i++)
            r.src[i] = s;
        return r;
    endfunction

    // One config write; cfg_valid is left high so back-to-back writes need
    // only one assignment per step. The caller drops it after the batch.
    task automatic cfg_write(logic [gf16ms_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // Writes every register plus the unused index. Upper data bits of the
    // count write are random, so masking to three bits is exercised too.
    task automatic program_regs(logic [2:0] cnt,
                                gf16ms_pkg::word_t [gf16ms_pkg::NUM_SRC-1:0] c);
        logic [15:0] d;
        d      = 16'($urandom);
        d[2:0] = cnt;
        cfg_write(gf16ms_pkg::REG_SOURCE_COUNT, d);
        for (int i = 0; i < gf16ms_pkg::NUM_SRC; i++)
            cfg_write(gf16ms_pkg::CFG_IDX_W'(int'(gf16ms_pkg::REG_COEF_A) + i), c[i]);
        cfg_write(REG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Present one request, hold it until taken, then maybe idle a little
    task automatic send_word(word_req_t r, int idle_pct);
        in_valid <= 1'b1;
        func     <= r.func;
        dst_word <= r.dst;
        src_a    <= r.src[0];
        src_b    <= r.src[1];
        src_c    <= r.src[2];
        src_d    <= r.src[3];
        src_e    <= r.src[4];
        src_f    <= r.src[5];
        last_in  <= r.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(r);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2))
                @(posedge clk);
        end
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        gf16ms_pkg::word_t [gf16ms_pkg::NUM_SRC-1:0] c;
        word_req_t           r;
        logic [2:0]          cnt;
        int                  idle_pct;
        int                  left;
        int                  len;
        logic                noisy;
        logic                buf_func;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- Directed part ---
        // Reset config: count 1, all coefficients zero, so multiply-add passes dst
        stall_pct = 0;
        send_word(make_req(gf16ms_pkg::FUNC_MULADD, 16'hFFFF, 16'hFFFF, 1'b1), 0);
        send_word(make_req(gf16ms_pkg::FUNC_MUL,    16'hFFFF, 16'hFFFF, 1'b0), 0);
        drain();

        // All six sources active, coefficients at the extremes
        c = {16'h7FFF, 16'h0002, 16'hFFFF, 16'h0001, 16'h8000, 16'hFFFF};
        program_regs(3'd6, c);
        send_word(make_req(gf16ms_pkg::FUNC_MULADD, 16'h0000, 16'h0000, 1'b0), 0);
        send_word(make_req(gf16ms_pkg::FUNC_MULADD, 16'hFFFF, 16'hFFFF, 1'b1), 0);
        send_word(make_req(gf16ms_pkg::FUNC_MUL,    16'hFFFF, 16'hFFFF, 1'b1), 0);
        send_word(make_req(gf16ms_pkg::FUNC_MUL,    16'h0000, 16'h8000, 1'b0), 0);
        send_word(make_req(gf16ms_pkg::FUNC_MULADD, 16'h5555, 16'hAAAA, 1'b0), 0);
        send_word(make_req(gf16ms_pkg::FUNC_MULADD, 16'hAAAA, 16'h5555, 1'b1), 0);
        send_word(make_req(gf16ms_pkg::FUNC_MULADD, 16'h0000, 16'h0001, 1'b0), 0);
        // Only source F carries data: later reuse shows whether source F is counted
        r = make_req(gf16ms_pkg::FUNC_MULADD, 16'h1234, 16'h0000, 1'b1);
        r.src[5] = 16'hFFFF;
        send_word(r, 0);
        drain();

        // Count of zero behaves as one; other sources and dst must be ignored
        // by multiply mode regardless of count
        c = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000};
        program_regs(3'd0, c);
        send_word(make_req(gf16ms_pkg::FUNC_MULADD, 16'hFFFF, 16'h8000, 1'b0), 0);
        send_word(r, 0);
        send_word(make_req(gf16ms_pkg::FUNC_MUL, 16'hFFFF, 16'hFFFF, 1'b1), 0);
        drain();

        // Count of seven saturates at six
        c = {16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'hFFFF};
        program_regs(3'd7, c);
        send_word(make_req(gf16ms_pkg::FUNC_MULADD, 16'h0000, 16'hFFFF, 1'b0), 0);
        send_word(r, 0);
        drain();

        // --- Random part: one register setting per phase ---
        for (int p = 0; p < PHASES; p++)
        begin
            cnt = (p == 9) ? 3'd6 : 3'(p % 8);
            for (int i = 0; i < gf16ms_pkg::NUM_SRC; i++)
                case (p)
                    1:       c[i] = 16'hFFFF;
                    2:       c[i] = 16'h0001;
                    5:       c[i] = 16'h0000;
                    default: c[i] = pick_word();
                endcase
            program_regs(cnt, c);

            // Phase four runs with no idling on either side
            idle_pct  = (p == 4) ? 0 : 30;
            stall_pct = idle_pct;

            left = PHASE_WORDS;
            while (left > 0)
            begin
                // Mostly whole buffers ending in last_in; some noise words
                noisy    = ($urandom_range(0, 9) == 0);
                len      = noisy ? 1 : $urandom_range(1, 24);
                buf_func = ($urandom_range(0, 99) < 75) ? gf16ms_pkg::FUNC_MULADD
                                                        : gf16ms_pkg::FUNC_MUL;
                if (len > left)
                    len = left;
                for (int j = 0; j < len; j++)
                begin
                    r.func = noisy ? 1'($urandom) : buf_func;
                    r.dst  = pick_word();
                    for (int i = 0; i < gf16ms_pkg::NUM_SRC; i++)
                        r.src[i] = ($urandom_range(0, 3) == 0) ? pick_word()
                                                               : 16'($urandom);
                    r.last = noisy ? 1'($urandom) : (j == len - 1);
                    send_word(r, idle_pct);
                end
                left -= len;
            end
            // Sender holds off until every result is back before reconfiguring
            drain();
        end

        // Let the pipeline settle with receiver stalls off
        stall_pct = 0;
        repeat (4)
            @(posedge clk);

        if (board.errors == 0)
            $display("** gf16_multi_source_muladd: PASSED **");
        else
            $display("** gf16_multi_source_muladd: FAILED **");
        $finish;
    end

endmodule
